// ----- design/drfs_pkg.sv -----
// Shared widths, command codes and register indexes for the frame slot sampler.
`default_nettype none

package drfs_pkg;

	localparam int STREAM_W   = 4;
	localparam int TAG_W      = 32;
	localparam int PHASE_W    = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [0:0] {
		CMD_SUBMIT = 1'b0,
		CMD_TAKE   = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EVERY_N = 1'b0,
		REG_ENABLE  = 1'b1
	} cfg_reg_t;

endpackage

`default_nettype wire

// ----- design/drfs_req_if.sv -----
// Request channel: submit and take commands.
`default_nettype none

interface drfs_req_if;
	import drfs_pkg::*;

	logic                valid;
	logic                ready;
	logic                command;
	logic [STREAM_W-1:0] stream;
	logic [TAG_W-1:0]    frame_tag;
	logic                frame_usable;

	modport source (output valid, command, stream, frame_tag, frame_usable, input ready);
	modport sink   (input valid, command, stream, frame_tag, frame_usable, output ready);
endinterface

`default_nettype wire

// ----- design/drfs_rsp_if.sv -----
// Response channel: one result beat per request.
`default_nettype none

interface drfs_rsp_if;
	import drfs_pkg::*;

	logic                valid;
	logic                ready;
	logic                stored;
	logic                took;
	logic [STREAM_W-1:0] out_stream;
	logic [TAG_W-1:0]    out_frame;

	modport source (output valid, stored, took, out_stream, out_frame, input ready);
	modport sink   (input valid, stored, took, out_stream, out_frame, output ready);
endinterface

`default_nettype wire

// ----- design/drfs_cfg_if.sv -----
// Configuration write channel.
`default_nettype none

interface drfs_cfg_if;
	import drfs_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/decimating_round_robin_frame_slots.sv -----
// Top level of the decimating round-robin frame slot sampler.
`default_nettype none

// Each stream keeps a phase counter that counts submits modulo every_n; on the
// submit that wraps it to zero, a usable frame replaces whatever tag is pending
// in that stream's single-entry slot. A take hands out the first full slot
// found in rotating order from the pointer, clears it and moves the pointer
// just past it; with nothing pending it returns all zeros. Every request beat
// yields exactly one response beat. One request is in work at a time: the
// beat is accepted while the phase and tag memories are read at the same edge
// into stage one; from there, once the response register is free or being
// taken, the state is modified, written back and the response register loaded.
// The next request is accepted only after that. The phase memory has per-entry
// valid flops that reset clears, so no clearing pass is needed after reset.
// Configuration writes are always taken and should be issued only while idle.
module decimating_round_robin_frame_slots #(
	parameter int NUM_STREAMS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	drfs_req_if.sink   req,
	drfs_rsp_if.source rsp,
	drfs_cfg_if.sink   cfg
);
	import drfs_pkg::*;

	localparam int IDX_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

	// Configuration registers.
	logic [PHASE_W-1:0] every_n_q;
	logic               enable_q;

	// State held outside the memories.
	logic [NUM_STREAMS-1:0] slot_full_q;
	logic [NUM_STREAMS-1:0] phase_valid_q;
	logic [IDX_W-1:0]       next_ptr_q;

	// Memories: per-stream phase counters and pending tags.
	logic [PHASE_W-1:0] phase_mem [NUM_STREAMS];
	logic [TAG_W-1:0]   tag_mem   [NUM_STREAMS];

	// Stage one holds the accepted request and the memory read data.
	logic               s1_valid_q;
	logic               take_s1;
	logic               submit_ok_s1;
	logic               usable_s1;
	logic [IDX_W-1:0]   addr_s1;
	logic [TAG_W-1:0]   tag_s1;
	logic               found_s1;
	logic [IDX_W-1:0]   pick_s1;
	logic               phase_vld_s1;
	logic [PHASE_W-1:0] phase_rd_s1;
	logic [TAG_W-1:0]   tag_rd_s1;

	// Response register.
	logic                out_valid_q;
	logic                stored_q;
	logic                took_q;
	logic [STREAM_W-1:0] out_stream_q;
	logic [TAG_W-1:0]    out_frame_q;

	logic               accept;
	logic               finish;
	logic               submit_ok;
	logic [IDX_W-1:0]   req_addr;
	logic               pick_found;
	logic [IDX_W-1:0]   pick_idx;
	logic [PHASE_W-1:0] n_eff;
	logic [PHASE_W-1:0] phase_cur;
	logic [PHASE_W:0]   phase_inc;
	logic               wrap;
	logic               keep;
	logic [PHASE_W-1:0] phase_new;
	logic [IDX_W-1:0]   ptr_after;

	assign req.ready = !s1_valid_q;
	assign accept    = req.valid && req.ready;
	assign finish    = s1_valid_q && (!out_valid_q || rsp.ready);
	assign cfg.ready = 1'b1;

	// A submit only counts while enabled and for a stream the table holds.
	assign submit_ok = enable_q && (int'(req.stream) < NUM_STREAMS);
	assign req_addr  = IDX_W'(req.stream);

	drfs_picker #(
		.NUM_STREAMS(NUM_STREAMS),
		.IDX_W      (IDX_W)
	) u_picker (
		.full (slot_full_q),
		.ptr  (next_ptr_q),
		.found(pick_found),
		.idx  (pick_idx)
	);

	// Decimation: a zero every_n behaves as one, and a counter left at or above
	// a lowered every_n wraps on its next submit.
	always_comb begin
		n_eff     = (every_n_q == '0) ? PHASE_W'(1) : every_n_q;
		phase_cur = phase_vld_s1 ? phase_rd_s1 : '0;
		phase_inc = {1'b0, phase_cur} + (PHASE_W + 1)'(1);
		wrap      = phase_inc >= {1'b0, n_eff};
		phase_new = wrap ? '0 : phase_inc[PHASE_W-1:0];
		keep      = !take_s1 && submit_ok_s1 && wrap && usable_s1;
		ptr_after = (pick_s1 == IDX_W'(NUM_STREAMS - 1)) ? '0 : pick_s1 + IDX_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			every_n_q <= PHASE_W'(1);
			enable_q  <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_EVERY_N: every_n_q <= cfg.data;
				REG_ENABLE:  enable_q  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q    <= 1'b0;
			out_valid_q   <= 1'b0;
			slot_full_q   <= '0;
			phase_valid_q <= '0;
			next_ptr_q    <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (finish) begin
				s1_valid_q <= 1'b0;
			end

			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			if (finish) begin
				if (take_s1) begin
					if (found_s1) begin
						slot_full_q[pick_s1] <= 1'b0;
						next_ptr_q           <= ptr_after;
					end
				end else if (submit_ok_s1) begin
					phase_valid_q[addr_s1] <= 1'b1;
					if (keep) begin
						slot_full_q[addr_s1] <= 1'b1;
					end
				end
			end
		end
	end

	// Request capture and synchronous memory reads at the accepting edge.
	always_ff @(posedge clk) begin
		if (accept) begin
			take_s1      <= (req.command == CMD_TAKE);
			submit_ok_s1 <= submit_ok;
			usable_s1    <= req.frame_usable;
			addr_s1      <= req_addr;
			tag_s1       <= req.frame_tag;
			found_s1     <= pick_found;
			pick_s1      <= pick_idx;
			phase_vld_s1 <= phase_valid_q[req_addr];
			phase_rd_s1  <= phase_mem[req_addr];
			tag_rd_s1    <= tag_mem[pick_idx];
		end
	end

	// Write-back. Only one request is ever in flight, so a read never
	// overlaps a write to the same entry.
	always_ff @(posedge clk) begin
		if (finish && !take_s1 && submit_ok_s1) begin
			phase_mem[addr_s1] <= phase_new;
		end
		if (finish && keep) begin
			tag_mem[addr_s1] <= tag_s1;
		end
	end

	// Response payload.
	always_ff @(posedge clk) begin
		if (finish) begin
			stored_q     <= keep;
			took_q       <= take_s1 && found_s1;
			out_stream_q <= (take_s1 && found_s1) ? STREAM_W'(pick_s1) : '0;
			out_frame_q  <= (take_s1 && found_s1) ? tag_rd_s1 : '0;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.stored     = stored_q;
	assign rsp.took       = took_q;
	assign rsp.out_stream = out_stream_q;
	assign rsp.out_frame  = out_frame_q;
endmodule

`default_nettype wire

// ----- design/drfs_picker.sv -----
// Rotating priority encoder that finds the first full slot at or after the pointer.
`default_nettype none

module drfs_picker #(
	parameter int NUM_STREAMS = 16,
	parameter int IDX_W       = 4
) (
	input  wire logic [NUM_STREAMS-1:0] full,
	input  wire logic [IDX_W-1:0]       ptr,
	output logic                        found,
	output logic [IDX_W-1:0]            idx
);
	logic             hi_found;
	logic [IDX_W-1:0] hi_idx;
	logic             lo_found;
	logic [IDX_W-1:0] lo_idx;

	// Scanning downward leaves the lowest hit in each half; the upper half
	// (slots at or past the pointer) wins, else the scan wraps to the bottom.
	always_comb begin
		hi_found = 1'b0;
		hi_idx   = '0;
		lo_found = 1'b0;
		lo_idx   = '0;
		for (int i = NUM_STREAMS - 1; i >= 0; i--) begin
			if (full[i]) begin
				lo_found = 1'b1;
				lo_idx   = IDX_W'(i);
				if (IDX_W'(i) >= ptr) begin
					hi_found = 1'b1;
					hi_idx   = IDX_W'(i);
				end
			end
		end
		found = lo_found;
		idx   = hi_found ? hi_idx : lo_idx;
	end
endmodule

`default_nettype wire

// ----- verif/drfs_slot_checker.sv -----
// Scoreboard for the frame slot sampler: predicts every response beat and compares it.
module drfs_slot_checker #(
	parameter int NUM_STREAMS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	drfs_req_if      req,
	drfs_rsp_if      rsp,
	drfs_cfg_if      cfg,
	output int       mismatches,
	output int       outstanding,
	output int       frames_stored,
	output int       frames_taken
);
	import drfs_pkg::*;

	typedef struct packed {
		logic                stored;
		logic                took;
		logic [STREAM_W-1:0] out_stream;
		logic [TAG_W-1:0]    out_frame;
	} slot_beat_t;

	logic [CFG_DATA_W-1:0] keep_every;
	logic                  submits_on;
	logic [PHASE_W-1:0]    phase [NUM_STREAMS];
	logic                  pending [NUM_STREAMS];
	logic [TAG_W-1:0]      held_tag [NUM_STREAMS];
	logic [STREAM_W-1:0]   rr_ptr;
	slot_beat_t            outcome_q [$];
	int                    errs;
	int                    n_stored;
	int                    n_taken;

	// Applies one request to the mirrored slot table and returns the beat it should produce.
	function automatic slot_beat_t frame_slot_outcome(logic command,
			logic [STREAM_W-1:0] stream, logic [TAG_W-1:0] tag, logic usable);
		slot_beat_t res;
		int         limit;
		int         advanced;
		int         idx;
		res = '0;
		if (command == CMD_SUBMIT) begin
			if (!submits_on || int'(stream) >= NUM_STREAMS)
				return res;
			// A period of zero behaves like one: every frame is kept.
			limit = (keep_every == '0) ? 1 : int'(keep_every);
			advanced = int'(phase[stream]) + 1;
			// A counter left above a lowered period wraps on the next submit.
			if (advanced >= limit) begin
				phase[stream] = '0;
				if (usable) begin
					pending[stream]  = 1'b1;
					held_tag[stream] = tag;
					res.stored       = 1'b1;
				end
			end else begin
				phase[stream] = advanced[PHASE_W-1:0];
			end
		end else begin
			for (int k = 0; k < NUM_STREAMS; k++) begin
				idx = (int'(rr_ptr) + k) % NUM_STREAMS;
				if (pending[idx]) begin
					res.took       = 1'b1;
					res.out_stream = idx[STREAM_W-1:0];
					res.out_frame  = held_tag[idx];
					pending[idx]   = 1'b0;
					rr_ptr         = STREAM_W'((idx + 1) % NUM_STREAMS);
					break;
				end
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		slot_beat_t got;
		slot_beat_t want;
		slot_beat_t predicted;
		if (!arst_n) begin
			keep_every = CFG_DATA_W'(1);
			submits_on = 1'b0;
			rr_ptr     = '0;
			for (int i = 0; i < NUM_STREAMS; i++) begin
				phase[i]    = '0;
				pending[i]  = 1'b0;
				held_tag[i] = '0;
			end
			outcome_q.delete();
			errs     = 0;
			n_stored = 0;
			n_taken  = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg_reg_t'(cfg.index))
					REG_EVERY_N: keep_every = cfg.data;
					REG_ENABLE:  submits_on = cfg.data[0];
					default: ;
				endcase
			end
			// Responses are checked before new requests so a beat never meets its own prediction.
			if (rsp.valid && rsp.ready) begin
				got = {rsp.stored, rsp.took, rsp.out_stream, rsp.out_frame};
				if (outcome_q.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display({"%0t: response beat with none expected: ",
							"stored %0b took %0b stream %0d frame %h"},
							$time, got.stored, got.took, got.out_stream, got.out_frame);
				end else begin
					want = outcome_q.pop_front();
					if (got.stored !== want.stored || got.took !== want.took ||
							got.out_stream !== want.out_stream ||
							got.out_frame !== want.out_frame) begin
						errs++;
						if (errs <= 10)
							$display({"%0t: mismatch: stored %0b/%0b took %0b/%0b ",
								"stream %0d/%0d frame %h/%h (expected/actual)"},
								$time, want.stored, got.stored, want.took, got.took,
								want.out_stream, got.out_stream, want.out_frame,
								got.out_frame);
					end
					if (want.stored)
						n_stored++;
					if (want.took)
						n_taken++;
				end
			end
			if (req.valid && req.ready) begin
				predicted = frame_slot_outcome(req.command, req.stream, req.frame_tag,
					req.frame_usable);
				outcome_q.insert(outcome_q.size(), predicted);
			end
		end
		mismatches    <= errs;
		outstanding   <= outcome_q.size();
		frames_stored <= n_stored;
		frames_taken  <= n_taken;
	end

endmodule

// ----- verif/tb.sv -----
// Testbench top for the frame slot sampler: clock, reset, stimulus and verdict.
module tb;
	import drfs_pkg::*;

	localparam int NUM_STREAMS   = 16;
	localparam int LONG_STALL    = 120;
	localparam int DRAIN_SETTLE  = 8;
	localparam int IDLE_LIMIT    = 3000;
	localparam int SEGMENT_BEATS = 48;
	localparam int TAKE_PCT      = 35;

	logic clk = 1'b0;
	logic arst_n;

	drfs_req_if req_ch ();
	drfs_rsp_if rsp_ch ();
	drfs_cfg_if cfg_ch ();

	int   mismatches;
	int   outstanding;
	int   frames_stored;
	int   frames_taken;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	logic stall_toggle = 1'b0;
	int   beats_sent = 0;
	int   settings_used = 0;
	int   idle_cycles = 0;

	decimating_round_robin_frame_slots #(
		.NUM_STREAMS(NUM_STREAMS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch),
		.cfg   (cfg_ch)
	);

	// The checker watches all three channels and reports its tallies back here.
	drfs_slot_checker #(
		.NUM_STREAMS(NUM_STREAMS)
	) slot_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_ch),
		.rsp          (rsp_ch),
		.cfg          (cfg_ch),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.frames_stored(frames_stored),
		.frames_taken (frames_taken)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Response side. Ready is drawn at random each cycle from the current idle
	// percentage. A flip of stall_toggle starts a long hold-off that this
	// process counts down itself; the sender keeps offering beats meanwhile, so
	// the block fills its one response register and must stall the request side.
	initial begin : response_side
		logic seen_toggle;
		int   hold_left;
		seen_toggle = 1'b0;
		hold_left   = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_toggle !== seen_toggle) begin
				seen_toggle = stall_toggle;
				hold_left   = LONG_STALL;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: any accepted beat on any channel counts as progress.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Offers one request beat, with random idle cycles ahead of it, and returns
	// at the edge where it was accepted. Valid stays high into the next beat
	// unless that beat begins with an idle cycle.
	task automatic send_frame_cmd(cmd_t command, logic [STREAM_W-1:0] stream,
			logic [TAG_W-1:0] tag, logic usable);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.command      <= command;
		req_ch.stream       <= stream;
		req_ch.frame_tag    <= tag;
		req_ch.frame_usable <= usable;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		beats_sent++;
	endtask

	// Stops offering requests and waits until every predicted response has come
	// back. The first edge lets the checker count the beat accepted just now.
	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Both registers are written back to back, only once the block is idle.
	task automatic apply_settings(logic [CFG_DATA_W-1:0] keep_every, logic submits_on);
		wait_for_results();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= REG_EVERY_N;
		cfg_ch.data  <= keep_every;
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1)
			@(posedge clk);
		cfg_ch.index <= REG_ENABLE;
		cfg_ch.data  <= {{(CFG_DATA_W-1){1'b0}}, submits_on};
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		settings_used++;
	endtask

	// Random traffic: a mix of takes and submits over all streams, with random
	// tags and mostly usable frames so the slots keep filling and draining.
	task automatic run_random_frames(int beats);
		cmd_t command;
		for (int i = 0; i < beats; i++) begin
			command = ($urandom_range(99) < TAKE_PCT) ? CMD_TAKE : CMD_SUBMIT;
			send_frame_cmd(command, STREAM_W'($urandom_range(NUM_STREAMS - 1)), $urandom,
				$urandom_range(99) < 80);
		end
	endtask

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] keep_pick [9];
		keep_pick = '{16'd1, 16'd2, 16'd3, 16'd0, 16'd4, 16'd65535, 16'd2, 16'd1, 16'd5};

		arst_n              <= 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.command      <= CMD_SUBMIT;
		req_ch.stream       <= '0;
		req_ch.frame_tag    <= '0;
		req_ch.frame_usable <= 1'b0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.index        <= REG_EVERY_N;
		cfg_ch.data         <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, run under the first idle profile.
		send_idle_pct = 33;
		recv_idle_pct <= 73;

		// While disabled a submit is ignored; a take on an empty table returns zeros.
		apply_settings(16'd1, 1'b0);
		send_frame_cmd(CMD_SUBMIT, 4'd3, 32'hCAFE_0003, 1'b1);
		send_frame_cmd(CMD_TAKE, 4'd0, 32'h0, 1'b0);

		// Keep every frame: the lowest and highest streams and tags, a replacement
		// of a pending tag, and an unusable frame that leaves its slot empty.
		apply_settings(16'd1, 1'b1);
		send_frame_cmd(CMD_SUBMIT, 4'd0, 32'hFFFF_FFFF, 1'b1);
		send_frame_cmd(CMD_SUBMIT, 4'd15, 32'h0000_0000, 1'b1);
		send_frame_cmd(CMD_SUBMIT, 4'd15, 32'h1234_5678, 1'b1);
		send_frame_cmd(CMD_SUBMIT, 4'd7, 32'h0BAD_F00D, 1'b0);
		// The pointer walks from stream 0 to 15 and wraps; the third take finds nothing.
		send_frame_cmd(CMD_TAKE, 4'd0, 32'h0, 1'b0);
		send_frame_cmd(CMD_TAKE, 4'd0, 32'h0, 1'b0);
		send_frame_cmd(CMD_TAKE, 4'd0, 32'h0, 1'b0);

		// A period of zero keeps every frame.
		apply_settings(16'd0, 1'b1);
		send_frame_cmd(CMD_SUBMIT, 4'd5, 32'h5555_AAAA, 1'b1);

		// One frame in three: the third submit stores, and in the next round of
		// three the wrap lands on an unusable frame, so the earlier tag stays.
		apply_settings(16'd3, 1'b1);
		send_frame_cmd(CMD_SUBMIT, 4'd9, 32'h9000_0001, 1'b1);
		send_frame_cmd(CMD_SUBMIT, 4'd9, 32'h9000_0002, 1'b1);
		send_frame_cmd(CMD_SUBMIT, 4'd9, 32'h9000_0003, 1'b1);
		send_frame_cmd(CMD_SUBMIT, 4'd9, 32'h9000_0004, 1'b1);
		send_frame_cmd(CMD_SUBMIT, 4'd9, 32'h9000_0005, 1'b1);
		send_frame_cmd(CMD_SUBMIT, 4'd9, 32'h9000_0006, 1'b0);

		// Largest period: the counter of stream 2 climbs to four, then the period
		// drops below it, and the next submit wraps and keeps its frame.
		apply_settings(16'd65535, 1'b1);
		repeat (4)
			send_frame_cmd(CMD_SUBMIT, 4'd2, 32'h2222_0000, 1'b1);
		apply_settings(16'd2, 1'b1);
		send_frame_cmd(CMD_SUBMIT, 4'd2, 32'hA5A5_5A5A, 1'b1);

		// Takes are still served while disabled, and the slots survive the change.
		apply_settings(16'd2, 1'b0);
		send_frame_cmd(CMD_TAKE, 4'd0, 32'h0, 1'b0);
		send_frame_cmd(CMD_TAKE, 4'd0, 32'h0, 1'b0);
		send_frame_cmd(CMD_TAKE, 4'd0, 32'h0, 1'b0);

		// Random part: three idle profiles, three register settings each.
		for (int p = 0; p < 3; p++) begin
			send_idle_pct = (p == 0) ? 33 : (p == 1) ? 73 : 0;
			recv_idle_pct <= (p == 0) ? 73 : (p == 1) ? 33 : 0;
			for (int s = 0; s < 3; s++) begin
				apply_settings(keep_pick[3 * p + s], !(p == 1 && s == 1));
				if (p == 0 && s == 1)
					stall_toggle <= ~stall_toggle;
				if (p == 2 && s == 0) begin
					// Sender pauses mid-segment until the block has answered everything.
					run_random_frames(SEGMENT_BEATS / 2);
					wait_for_results();
					run_random_frames(SEGMENT_BEATS / 2);
				end else begin
					run_random_frames(SEGMENT_BEATS);
				end
			end
		end

		wait_for_results();
		repeat (DRAIN_SETTLE) @(posedge clk);
		$display("Covered %0d request beats under %0d register settings and three idle profiles.",
			beats_sent, settings_used);
		$display("Frames stored: %0d, frames handed out: %0d, mismatching beats: %0d.",
			frames_stored, frames_taken, mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
